// ===== rtl/core/byte_ring_buffer_fifo_macros.svh =====
// ----------------------------------------------------------------------------
// Byte ring buffer FIFO assertion macros
// Concurrent checks sampled on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_FIFO_MACROS_SVH
`define BYTE_RING_BUFFER_FIFO_MACROS_SVH

// Same-cycle implication.
`define BRBF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BRBF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/brbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte ring buffer FIFO package
// Payload structs, operation codes, controller states and command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brbf_pkg;

  localparam int DATA_W  = 8;
  localparam int CFG_W   = 9;
  localparam int DROP_W  = 16;
  localparam int FUNC_W  = 2;

  localparam logic [FUNC_W-1:0] OP_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] OP_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [DROP_W-1:0] DROP_MAX = 16'hFFFF;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] write_data;
    logic              burst_start;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              status;
    logic [DATA_W-1:0] fill_count;
    logic [DATA_W-1:0] free_count;
    logic [DROP_W-1:0] drop_count;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;   // capture the incoming beat
    logic exec;   // run the captured operation
  } brbf_cmd_t;

endpackage

// ===== rtl/core/byte_ring_buffer_fifo.sv =====
// Result strobe: raised in the controller's result state, which follows the execute state entered on acceptance.
// Operations do not overlap: in the controller's execute state busy is high and no beat is taken.
// A new beat is taken in the same cycle its predecessor's result is on the port.
// Synchronous active-low reset: pointers and drop count zero, ring size 256 (capped at MAX_DEPTH).
// The ring store is not cleared; results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// Byte ring buffer FIFO
// Byte FIFO on a ring store with a configurable wrap point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_ring_buffer_fifo
  import brbf_pkg::*;
#(
  parameter int MAX_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  brbf_cmd_t cmd;

  brbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  brbf_dpath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/core/brbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Byte ring buffer FIFO controller
// Sequences capture, execute and result strobe for each operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_ring_buffer_fifo_macros.svh"

module brbf_ctrl
  import brbf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output brbf_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        // take the next beat while the result is on the port
        state_nxt = start ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = (state_r == ST_EXEC);
    out_valid = (state_r == ST_RESP);
    cmd.load  = start && (state_r != ST_EXEC);
    cmd.exec  = (state_r == ST_EXEC);
  end

  `BRBF_ASSERT_NXT(a_accept_runs, cmd.load, cmd.exec && busy, "accepted beat not executed")
  `BRBF_ASSERT_NXT(a_exec_strobes, cmd.exec, out_valid && !busy, "execute not followed by result")

endmodule

// ===== rtl/core/brbf_dpath.sv =====
// ----------------------------------------------------------------------------
// Byte ring buffer FIFO datapath
// Ring store, pointers, drop counter, size register and result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_ring_buffer_fifo_macros.svh"

module brbf_dpath
  import brbf_pkg::*;
#(
  parameter int MAX_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  brbf_cmd_t        cmd,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output out_item_t        out_item
);

  localparam int PTR_W    = (MAX_DEPTH > 2) ? $clog2(MAX_DEPTH) : 1;
  localparam int SIZE_W   = $clog2(MAX_DEPTH + 1);
  localparam int CMP_W    = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
  localparam int SIZE_RST = (MAX_DEPTH < 256) ? MAX_DEPTH : 256;

  logic [DATA_W-1:0] ring_mem [MAX_DEPTH];

  in_item_t          item_r;
  logic [PTR_W-1:0]  wp_r,   wp_nxt;
  logic [PTR_W-1:0]  rp_r,   rp_nxt;
  logic [DROP_W-1:0] drop_r, drop_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic              status_r, status_nxt;
  logic [DATA_W-1:0] rdata_r;

  logic [SIZE_W-1:0] wp_inc;
  logic [SIZE_W-1:0] rp_inc;
  logic [PTR_W-1:0]  wp_adv;
  logic [PTR_W-1:0]  rp_adv;
  logic              full;
  logic              empty;
  logic [DROP_W-1:0] drop_base;
  logic [CMP_W-1:0]  cfg_ext;
  logic [SIZE_W-1:0] fill;
  logic [SIZE_W-1:0] space;
  logic              do_write;
  logic              do_read;

  // pointer advance with wrap at the configured size
  assign wp_inc = SIZE_W'(wp_r) + SIZE_W'(1);
  assign rp_inc = SIZE_W'(rp_r) + SIZE_W'(1);
  assign wp_adv = (wp_inc >= size_r) ? '0 : PTR_W'(wp_inc);
  assign rp_adv = (rp_inc >= size_r) ? '0 : PTR_W'(rp_inc);
  assign full   = (wp_adv == rp_r);
  assign empty  = (wp_r == rp_r);

  assign do_write = cmd.exec && (item_r.func == OP_WRITE) && !full;
  assign do_read  = cmd.exec && (item_r.func == OP_READ) && !empty;

  assign drop_base = item_r.burst_start ? '0 : drop_r;
  assign cfg_ext   = CMP_W'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
  end

  always_ff @(posedge clk) begin
    if (do_write) ring_mem[wp_r] <= item_r.write_data;
  end

  // registered read port; a refused read returns zero
  always_ff @(posedge clk) begin
    if (do_read) begin
      rdata_r <= ring_mem[rp_r];
    end else if (cmd.exec) begin
      rdata_r <= '0;
    end
  end

  always_comb begin
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    drop_nxt   = drop_r;
    size_nxt   = size_r;
    status_nxt = status_r;
    if (cfg_we) begin
      priority if (cfg_ext < CMP_W'(2)) begin
        size_nxt = SIZE_W'(2);
      end else if (cfg_ext > CMP_W'(MAX_DEPTH)) begin
        size_nxt = SIZE_W'(MAX_DEPTH);
      end else begin
        size_nxt = SIZE_W'(cfg_ext);
      end
      wp_nxt   = '0;
      rp_nxt   = '0;
      drop_nxt = '0;
    end else if (cmd.exec) begin
      status_nxt = 1'b0;
      unique case (item_r.func)
        OP_WRITE: begin
          if (full) begin
            status_nxt = 1'b1;
            drop_nxt   = (drop_base != DROP_MAX) ? drop_base + DROP_W'(1) : drop_base;
          end else begin
            wp_nxt   = wp_adv;
            drop_nxt = drop_base;
          end
        end
        OP_READ: begin
          if (empty) begin
            status_nxt = 1'b1;
          end else begin
            rp_nxt = rp_adv;
          end
        end
        OP_CLEAR: begin
          wp_nxt   = '0;
          rp_nxt   = '0;
          drop_nxt = '0;
        end
        default: begin
          // unused code: hold pointers and drop count; status clears
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      rp_r     <= '0;
      drop_r   <= '0;
      size_r   <= SIZE_W'(SIZE_RST);
      status_r <= 1'b0;
    end else begin
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      drop_r   <= drop_nxt;
      size_r   <= size_nxt;
      status_r <= status_nxt;
    end
  end

  // fill level from the settled pointers
  assign fill  = (wp_r >= rp_r) ? SIZE_W'(wp_r) - SIZE_W'(rp_r)
                                : size_r - SIZE_W'(rp_r) + SIZE_W'(wp_r);
  assign space = size_r - SIZE_W'(1) - fill;

  always_comb begin
    out_item.read_data  = rdata_r;
    out_item.status     = status_r;
    out_item.fill_count = DATA_W'(fill);
    out_item.free_count = DATA_W'(space);
    out_item.drop_count = drop_r;
  end

  `BRBF_ASSERT_IMP(a_wp_in_ring, 1'b1, SIZE_W'(wp_r) < size_r, "write pointer beyond ring")
  `BRBF_ASSERT_IMP(a_rp_in_ring, 1'b1, SIZE_W'(rp_r) < size_r, "read pointer beyond ring")
  `BRBF_ASSERT_NXT(a_full_holds_wp,
                   cmd.exec && !cfg_we && (item_r.func == OP_WRITE) && full,
                   wp_r == $past(wp_r) && status_r, "refused write moved pointer")

endmodule
